// ===== hdl/tdrq_pkg.sv =====
`default_nettype none

package tdrq_pkg;

    // Slot field width and the number of slots it can address.
    localparam int SLOT_W        = 4;
    localparam int SLOT_LIMIT    = 16;
    localparam int DEF_MAX_TASKS = 16;
    localparam int TIME_W        = 32;

    localparam logic [TIME_W-1:0] NO_WAKE = '1;

    // Request kinds carried on the input tuser bit.
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_DELAY = 1'b1;

    // Stream data widths, padded to whole bytes.
    localparam int DATA_W = ((SLOT_W + TIME_W + 7) / 8) * 8;

    typedef struct packed {
        logic                req_type;
        logic [SLOT_W-1:0]   task_slot;
        logic [TIME_W-1:0]   delay_ticks;
    } item_t;

endpackage

`default_nettype wire

// ===== hdl/tdrq_front.sv =====
`default_nettype none

module tdrq_front
    import tdrq_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    output logic       q_valid,
    output item_t      q_item,
    input  wire logic  q_pop
);

    // Two-entry queue that decouples the stream input from the engine.
    item_t       mem_reg [2];
    logic        wptr_reg, wptr_next;
    logic        rptr_reg, rptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;
    logic        pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_comb begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tdrq_back.sv =====
`default_nettype none

module tdrq_back
    import tdrq_pkg::*;
#(
    parameter int MAX_TASKS = DEF_MAX_TASKS
)(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    input  wire item_t              q_item,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [SLOT_W-1:0]       out_task,
    output logic [TIME_W-1:0]       out_wake,
    output logic                    out_last
);

    localparam int NSLOT = (MAX_TASKS < SLOT_LIMIT) ? MAX_TASKS : SLOT_LIMIT;
    localparam int IW    = $clog2(NSLOT);
    localparam logic [IW-1:0] LAST_IDX = IW'(NSLOT - 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_DECIDE = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic                 wrap_scan_reg, wrap_scan_next;
    logic [TIME_W-1:0]    cnt_reg, cnt_next;
    logic [TIME_W-1:0]    earliest_reg, earliest_next;
    logic                 bank_reg, bank_next;
    logic [TIME_W-1:0]    ic_reg, ic_next;
    logic [NSLOT-1:0]     waiting_reg;

    logic [TIME_W-1:0]    wake_reg  [NSLOT];
    logic                 ebank_reg [NSLOT];
    logic [TIME_W-1:0]    order_reg [NSLOT];

    logic [IW-1:0]        idx_reg, idx_next;
    logic                 found_reg, found_next;
    logic [IW-1:0]        bidx_reg, bidx_next;
    logic [TIME_W-1:0]    bwake_reg, bwake_next;
    logic [TIME_W-1:0]    bage_reg, bage_next;

    logic                 pend_valid_reg, pend_valid_next;
    logic [IW-1:0]        pend_idx_reg, pend_idx_next;
    logic [TIME_W-1:0]    pend_wake_reg, pend_wake_next;

    logic                 out_valid_reg;
    logic [SLOT_W-1:0]    out_task_reg;
    logic [TIME_W-1:0]    out_wake_reg;
    logic                 out_last_reg;

    logic                 push;
    logic                 push_last;
    logic                 out_free;
    logic                 wr_en;
    logic                 clr_en;
    logic [IW-1:0]        wr_idx;
    logic                 wr_bank;
    logic [TIME_W-1:0]    new_wake;
    logic                 slot_ok;
    logic                 cand;
    logic [TIME_W-1:0]    cand_age;
    logic                 better;
    logic [TIME_W-1:0]    new_earliest;

    assign out_valid = out_valid_reg;
    assign out_task  = out_task_reg;
    assign out_wake  = out_wake_reg;
    assign out_last  = out_last_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign new_wake = cnt_reg + q_item.delay_ticks;
    assign slot_ok  = ({{(TIME_W-SLOT_W){1'b0}}, q_item.task_slot} < TIME_W'(NSLOT));
    assign wr_idx   = q_item.task_slot[IW-1:0];
    assign wr_bank  = (new_wake < cnt_reg) ? ~bank_reg : bank_reg;

    assign cand     = waiting_reg[idx_reg] && (ebank_reg[idx_reg] == bank_reg);
    assign cand_age = ic_reg - order_reg[idx_reg];
    assign better   = !found_reg || (wake_reg[idx_reg] < bwake_reg)
                      || ((wake_reg[idx_reg] == bwake_reg) && (cand_age > bage_reg));
    assign new_earliest = found_reg ? bwake_reg : NO_WAKE;

    always_comb begin
        state_next      = state_reg;
        wrap_scan_next  = wrap_scan_reg;
        cnt_next        = cnt_reg;
        earliest_next   = earliest_reg;
        bank_next       = bank_reg;
        ic_next         = ic_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        bidx_next       = bidx_reg;
        bwake_next      = bwake_reg;
        bage_next       = bage_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_wake_next  = pend_wake_reg;
        q_pop           = 1'b0;
        push            = 1'b0;
        push_last       = 1'b0;
        wr_en           = 1'b0;
        clr_en          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_item.req_type == REQ_DELAY) begin
                        if (slot_ok) begin
                            wr_en   = 1'b1;
                            ic_next = ic_reg + 1'b1;
                            if (!(new_wake < cnt_reg) && (new_wake < earliest_reg)) begin
                                earliest_next = new_wake;
                            end
                        end
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                        if (cnt_next == '0) begin
                            bank_next      = ~bank_reg;
                            wrap_scan_next = 1'b1;
                            state_next     = ST_SCAN;
                            idx_next       = '0;
                            found_next     = 1'b0;
                        end else if (cnt_next >= earliest_reg) begin
                            wrap_scan_next = 1'b0;
                            state_next     = ST_SCAN;
                            idx_next       = '0;
                            found_next     = 1'b0;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (cand && better) begin
                    found_next = 1'b1;
                    bidx_next  = idx_reg;
                    bwake_next = wake_reg[idx_reg];
                    bage_next  = cand_age;
                end
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_DECIDE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DECIDE: begin
                if (wrap_scan_reg) begin
                    earliest_next = new_earliest;
                    if (cnt_reg >= new_earliest) begin
                        wrap_scan_next = 1'b0;
                        state_next     = ST_SCAN;
                        idx_next       = '0;
                        found_next     = 1'b0;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else if (found_reg && (cnt_reg >= bwake_reg)) begin
                    if (!pend_valid_reg || out_free) begin
                        push            = pend_valid_reg;
                        clr_en          = 1'b1;
                        pend_valid_next = 1'b1;
                        pend_idx_next   = bidx_reg;
                        pend_wake_next  = bwake_reg;
                        state_next      = ST_SCAN;
                        idx_next        = '0;
                        found_next      = 1'b0;
                    end
                end else begin
                    earliest_next = new_earliest;
                    if (!pend_valid_reg) begin
                        state_next = ST_IDLE;
                    end else if (out_free) begin
                        push            = 1'b1;
                        push_last       = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            wrap_scan_reg  <= 1'b0;
            cnt_reg        <= '0;
            earliest_reg   <= NO_WAKE;
            bank_reg       <= 1'b0;
            ic_reg         <= '0;
            waiting_reg    <= '0;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            wrap_scan_reg  <= wrap_scan_next;
            cnt_reg        <= cnt_next;
            earliest_reg   <= earliest_next;
            bank_reg       <= bank_next;
            ic_reg         <= ic_next;
            idx_reg        <= idx_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            if (wr_en) begin
                waiting_reg[wr_idx] <= 1'b1;
            end
            if (clr_en) begin
                waiting_reg[bidx_reg] <= 1'b0;
            end
            if (push) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        bidx_reg      <= bidx_next;
        bwake_reg     <= bwake_next;
        bage_reg      <= bage_next;
        pend_idx_reg  <= pend_idx_next;
        pend_wake_reg <= pend_wake_next;
        if (wr_en) begin
            wake_reg[wr_idx]  <= new_wake;
            ebank_reg[wr_idx] <= wr_bank;
            order_reg[wr_idx] <= ic_reg;
        end
        if (push) begin
            out_task_reg <= SLOT_W'(pend_idx_reg);
            out_wake_reg <= pend_wake_reg;
            out_last_reg <= push_last;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tick_delay_release_queue.sv =====
// Kernel tick delay manager.
// The input stream carries one request per word: s_tuser is the request kind
// (0 = one kernel tick, 1 = delay request), and s_tdata holds the task slot and
// the delay in ticks. A delay request stores the task's wake time, the tick
// count plus the delay with 32-bit wrap, and produces no output word.
// A tick advances the count and releases every due task of the current bank
// as one output word each, in wake-time order with ties in insertion order.
// m_tlast marks the final release of a tick.
// Requests pass through a two-word queue, so the input keeps accepting while
// the engine works. A delay request for a slot at or past MAX_TASKS is dropped.
// Each scan of the task table visits one entry per cycle over MAX_TASKS entries,
// capped at 16, and then decides; a tick that reaches the earliest wake time
// runs one scan per released task plus one closing scan, with one more scan on
// a count wrap. The sequential table scan sets the rate.
// After reset the count is zero, no task waits and the queue is empty.
// When the receiver stalls, the held release waits in the output register and
// the engine pauses; the input queue fills and then drops s_tready.
`default_nettype none

module tick_delay_release_queue
    import tdrq_pkg::*;
#(
    parameter int MAX_TASKS = DEF_MAX_TASKS
)(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // [3:0] task_slot, [35:4] delay_ticks, [39:36] zero
    input  wire logic [DATA_W-1:0] s_tdata,
    // [0] req_type
    input  wire logic              s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // [3:0] released_task, [35:4] released_wake_time, [39:36] zero
    output logic [DATA_W-1:0]      m_tdata,
    output logic                   m_tlast
);

    item_t              in_item;
    item_t              q_item;
    logic               q_valid;
    logic               q_pop;
    logic [SLOT_W-1:0]  out_task;
    logic [TIME_W-1:0]  out_wake;

    // Unpack the input word into one request.
    assign in_item.req_type    = s_tuser;
    assign in_item.task_slot   = s_tdata[SLOT_W-1:0];
    assign in_item.delay_ticks = s_tdata[SLOT_W+TIME_W-1:SLOT_W];

    tdrq_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    tdrq_back #(
        .MAX_TASKS (MAX_TASKS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_task  (out_task),
        .out_wake  (out_wake),
        .out_last  (m_tlast)
    );

    // Pack the release into the output word, padding with zeros.
    assign m_tdata = {{(DATA_W-SLOT_W-TIME_W){1'b0}}, out_wake, out_task};

endmodule

`default_nettype wire
